>>> rtl/pps_pkg.sv
// shared constants, register codes and stage bundles for the point-to-screen projector
package pps_pkg;

	// eye coordinate, product and quotient widths
	localparam int EW = 51;
	localparam int PW = 86;
	localparam int NW = 85;
	localparam int SZW = 16;
	localparam int SPW = NW + SZW;
	localparam int QW = 32;
	localparam int FB = 16;
	localparam int CH = 29;
	localparam int SPLIT = 26;

	// pipeline depths
	localparam int XFORM_STAGES = 2;
	localparam int PROJ_STAGES = 6;
	localparam int DIV_STAGES = QW + 1;
	localparam int NV = XFORM_STAGES + PROJ_STAGES + DIV_STAGES;
	localparam int FC = PROJ_STAGES + DIV_STAGES;

	// configuration port
	localparam int AW = 6;
	localparam int DW = 64;

	localparam logic [QW-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		REG_ROW_X,
		REG_ROW_Y,
		REG_ROW_Z,
		REG_NEAR,
		REG_FRUSTUM_H,
		REG_FRUSTUM_V,
		REG_SCREEN_SIZE
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] row_x;
		logic [63:0] row_y;
		logic [63:0] row_z;
		logic [30:0] near;
		logic [63:0] frustum_h;
		logic [63:0] frustum_v;
		logic [31:0] size;
	} cfg_t;

	typedef struct packed {
		logic signed [EW-1:0] xe;
		logic signed [EW-1:0] ye;
		logic signed [EW-1:0] ze;
		logic [EW-2:0] aze;
		logic [31:0] w;
		logic [31:0] h;
		logic signed [34:0] hb;
	} eye_t;

	typedef struct packed {
		logic [SPW-1:0] px;
		logic [SPW-1:0] py;
		logic [NW-1:0] dx;
		logic [NW-1:0] dy;
		logic negx;
		logic negy;
	} scaled_t;

endpackage

>>> rtl/pps_if.sv
// request channels for points in and screen coordinates out
interface pps_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pps_screen_if;
	logic valid;
	logic ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic fault;

	modport source (output valid, output screen_x, output screen_y, output fault, input ready);
	modport sink (input valid, input screen_x, input screen_y, input fault, output ready);
endinterface

>>> rtl/pps_xform.sv
// model-view transform: point to eye space, frustum extents and fault check
module pps_xform import pps_pkg::*; (
	input logic clk,
	input logic en,
	input cfg_t cfg,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	output eye_t eye_s2,
	output logic fault_s2
);

	logic [63:0] rows [3];
	logic signed [31:0] pos [3];
	logic signed [47:0] prod_s1 [3][3];
	logic signed [EW-1:0] sum [3];
	logic signed [EW-1:0] trans [3];
	logic signed [32:0] dw, dh;
	eye_t eye_c;

	// operand selection
	always_comb begin
		rows[0] = cfg.row_x;
		rows[1] = cfg.row_y;
		rows[2] = cfg.row_z;
		pos[0] = pos_x;
		pos[1] = pos_y;
		pos[2] = pos_z;
	end

	// stage 1: nine coefficient products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= pos[c] * $signed(rows[r][16*c +: 16]);
				end
			end
		end
	end

	// row sums with translation, extents
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			trans[r] = $signed({{(EW-40){rows[r][63]}}, rows[r][63:48], 24'b0});
			sum[r] = EW'(prod_s1[r][0]) + EW'(prod_s1[r][1]) + EW'(prod_s1[r][2]) + trans[r];
		end
		dw = $signed({cfg.frustum_h[63], cfg.frustum_h[63:32]})
			- $signed({cfg.frustum_h[31], cfg.frustum_h[31:0]});
		dh = $signed({cfg.frustum_v[63], cfg.frustum_v[63:32]})
			- $signed({cfg.frustum_v[31], cfg.frustum_v[31:0]});
		eye_c.xe = sum[0];
		eye_c.ye = sum[1];
		eye_c.ze = sum[2];
		eye_c.aze = sum[2][EW-1] ? (EW-1)'(-sum[2]) : sum[2][EW-2:0];
		eye_c.w = dw[32] ? 32'(-dw) : dw[31:0];
		eye_c.h = dh[32] ? 32'(-dh) : dh[31:0];
		eye_c.hb = $signed({3'b0, eye_c.h}) + 35'($signed(cfg.frustum_v[31:0]));
	end

	// stage 2: eye space register
	always_ff @(posedge clk) begin
		if (en) begin
			eye_s2 <= eye_c;
			fault_s2 <= (sum[2] == '0) || (eye_c.w == '0) || (eye_c.h == '0);
		end
	end

endmodule

>>> rtl/pps_proj.sv
// projection numerators, denominators and screen scale, split multiplies
module pps_proj import pps_pkg::*; (
	input logic clk,
	input logic en,
	input cfg_t cfg,
	input eye_t eye,
	output scaled_t sc_s8
);

	logic signed [EW-1:0] op_a [6];
	logic signed [34:0] op_b [6];
	logic signed [61:0] lo_s3 [6];
	logic signed [59:0] hi_s3 [6];
	logic negz_s3, negz_s4, negz_s5;
	logic signed [PW-1:0] full_s4 [6];
	logic signed [PW-1:0] num_s5 [2];
	logic [NW-1:0] den_s5 [2];
	logic [NW-1:0] mag_s6 [2];
	logic [NW-1:0] den_s6 [2];
	logic neg_s6 [2];
	logic [NW-1:0] den_s7 [2];
	logic neg_s7 [2];
	logic [CH+SZW-1:0] part_s7 [2][3];
	logic [CH*3-1:0] magp [2];
	logic [SZW-1:0] sz [2];

	// multiply operands
	always_comb begin
		op_a[0] = eye.xe;
		op_a[1] = eye.ze;
		op_a[2] = eye.ze;
		op_a[3] = eye.ye;
		op_a[4] = $signed({1'b0, eye.aze});
		op_a[5] = $signed({1'b0, eye.aze});
		op_b[0] = $signed({4'b0, cfg.near});
		op_b[1] = 35'($signed(cfg.frustum_h[31:0]));
		op_b[2] = eye.hb;
		op_b[3] = $signed({4'b0, cfg.near});
		op_b[4] = $signed({3'b0, eye.w});
		op_b[5] = $signed({3'b0, eye.h});
		sz[0] = cfg.size[31:16];
		sz[1] = cfg.size[15:0];
		for (int i = 0; i < 2; i++) begin
			magp[i] = {2'b0, mag_s6[i]};
		end
	end

	// stages 3 to 8
	always_ff @(posedge clk) begin
		if (en) begin
			// low and high halves of each wide product
			for (int k = 0; k < 6; k++) begin
				lo_s3[k] <= $signed({1'b0, op_a[k][SPLIT-1:0]}) * op_b[k];
				hi_s3[k] <= $signed(op_a[k][EW-1:SPLIT]) * op_b[k];
			end
			negz_s3 <= eye.ze[EW-1];
			// recombine halves
			for (int k = 0; k < 6; k++) begin
				full_s4[k] <= (PW'(hi_s3[k]) <<< SPLIT) + PW'(lo_s3[k]);
			end
			negz_s4 <= negz_s3;
			// numerators and denominators
			num_s5[0] <= -(full_s4[0] + full_s4[1]);
			num_s5[1] <= full_s4[2] + full_s4[3];
			den_s5[0] <= full_s4[4][NW-1:0];
			den_s5[1] <= full_s4[5][NW-1:0];
			negz_s5 <= negz_s4;
			// magnitudes and quotient sign
			for (int i = 0; i < 2; i++) begin
				mag_s6[i] <= num_s5[i][PW-1] ? NW'(-num_s5[i]) : num_s5[i][NW-1:0];
				neg_s6[i] <= num_s5[i][PW-1] ^ negz_s5;
				den_s6[i] <= den_s5[i];
			end
			// screen size partial products
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 3; j++) begin
					part_s7[i][j] <= magp[i][CH*j +: CH] * sz[i];
				end
				den_s7[i] <= den_s6[i];
				neg_s7[i] <= neg_s6[i];
			end
			sc_s8.px <= SPW'(part_s7[0][0]) + (SPW'(part_s7[0][1]) << CH)
				+ (SPW'(part_s7[0][2]) << (2*CH));
			sc_s8.py <= SPW'(part_s7[1][0]) + (SPW'(part_s7[1][1]) << CH)
				+ (SPW'(part_s7[1][2]) << (2*CH));
			sc_s8.dx <= den_s7[0];
			sc_s8.dy <= den_s7[1];
			sc_s8.negx <= neg_s7[0];
			sc_s8.negy <= neg_s7[1];
		end
	end

endmodule

>>> rtl/pps_div.sv
// pipelined restoring divider, one quotient bit per stage, saturated result
module pps_div import pps_pkg::*; (
	input logic clk,
	input logic en,
	input logic [SPW-1:0] num,
	input logic [NW-1:0] den,
	input logic neg,
	output logic signed [QW-1:0] res
);

	logic [NW-1:0] rem_s [DIV_STAGES];
	logic [NW-1:0] den_s [DIV_STAGES];
	logic [QW-1:0] low_s [DIV_STAGES];
	logic [QW-1:0] quo_s [DIV_STAGES];
	logic neg_s [DIV_STAGES];
	logic ovf_s [DIV_STAGES];
	logic [NW:0] trial [1:QW];
	logic take [1:QW];
	logic [QW-1:0] q;

	// trial subtract per stage
	always_comb begin
		for (int k = 1; k <= QW; k++) begin
			trial[k] = {rem_s[k-1], low_s[k-1][QW-1]};
			take[k] = trial[k] >= {1'b0, den_s[k-1]};
		end
	end

	// entry stage checks for a quotient beyond 32 bits, then one bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num[SPW-1:FB];
			ovf_s[0] <= num[SPW-1:FB] >= den;
			low_s[0] <= {num[FB-1:0], FB'(0)};
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			for (int k = 1; k <= QW; k++) begin
				rem_s[k] <= take[k] ? NW'(trial[k] - {1'b0, den_s[k-1]}) : trial[k][NW-1:0];
				quo_s[k] <= {quo_s[k-1][QW-2:0], take[k]};
				low_s[k] <= {low_s[k-1][QW-2:0], 1'b0};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	// sign and saturation
	always_comb begin
		q = quo_s[QW];
		if (!neg_s[QW]) begin
			res = (ovf_s[QW] || q[QW-1]) ? $signed(SAT_MAX) : $signed(q);
		end else begin
			res = (ovf_s[QW] || q > SAT_MIN) ? $signed(SAT_MIN) : $signed(-q);
		end
	end

endmodule

>>> rtl/perspective_point_to_screen.sv
// top level: register port, input skid, projection pipeline and result register
// Projects one Q16.16 point per clock, unless stalled, to Q16.16 screen pixels
// with y from the top. An accepted request passes the model-view transform,
// the split wide multiplies and scaling, the restoring divider that yields one
// quotient bit per stage, and the result register. A whole-pipeline enable
// stalls when the result is not taken; a one-entry input skid still takes one
// request during such a stall. Registers are to be written over the APB port
// only while no request is in flight; the block does not enforce this. Each
// takes a 64-bit slot at byte address 8*index. A zero depth or zero frustum
// extent gives fault with zero coordinates.
module perspective_point_to_screen import pps_pkg::*; (
	input logic clk,
	input logic arst_n,
	pps_point_if.sink point,
	pps_screen_if.source screen,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [AW-1:0] paddr,
	input logic [DW-1:0] pwdata,
	output logic [DW-1:0] prdata,
	output logic pready
);

	cfg_t cfg;
	reg_idx_t idx;
	logic wr;
	logic en;
	logic skid_full_q;
	logic signed [31:0] skid_x_q, skid_y_q, skid_z_q;
	logic signed [31:0] src_x, src_y, src_z;
	logic src_valid;
	logic [NV-1:0] v_s;
	logic [FC-1:0] fc_s;
	eye_t eye_s2;
	logic fault_s2;
	scaled_t sc_s8;
	logic signed [QW-1:0] res_x, res_y;
	logic out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic out_fault_q;

	// register port
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[AW-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.row_x <= '0;
			cfg.row_y <= '0;
			cfg.row_z <= '0;
			cfg.near <= 31'd65536;
			cfg.frustum_h <= '0;
			cfg.frustum_v <= '0;
			cfg.size <= '0;
		end else if (wr) begin
			case (idx)
				REG_ROW_X: cfg.row_x <= pwdata;
				REG_ROW_Y: cfg.row_y <= pwdata;
				REG_ROW_Z: cfg.row_z <= pwdata;
				REG_NEAR: cfg.near <= pwdata[30:0];
				REG_FRUSTUM_H: cfg.frustum_h <= pwdata;
				REG_FRUSTUM_V: cfg.frustum_v <= pwdata;
				REG_SCREEN_SIZE: cfg.size <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (idx)
			REG_ROW_X: prdata = cfg.row_x;
			REG_ROW_Y: prdata = cfg.row_y;
			REG_ROW_Z: prdata = cfg.row_z;
			REG_NEAR: prdata = {33'b0, cfg.near};
			REG_FRUSTUM_H: prdata = cfg.frustum_h;
			REG_FRUSTUM_V: prdata = cfg.frustum_v;
			REG_SCREEN_SIZE: prdata = {32'b0, cfg.size};
			default: prdata = '0;
		endcase
	end

	// pipeline advances whenever the result register can move
	assign en = !out_valid_q || screen.ready;
	assign point.ready = !skid_full_q;

	// input skid holds one request taken during a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (point.valid && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && point.valid && !skid_full_q) begin
			skid_x_q <= point.pos_x;
			skid_y_q <= point.pos_y;
			skid_z_q <= point.pos_z;
		end
	end

	// pipeline source
	always_comb begin
		src_valid = skid_full_q || point.valid;
		src_x = skid_full_q ? skid_x_q : point.pos_x;
		src_y = skid_full_q ? skid_y_q : point.pos_y;
		src_z = skid_full_q ? skid_z_q : point.pos_z;
	end

	// valid bits travel with the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NV-2:0], src_valid};
		end
	end

	// fault flag follows its item
	always_ff @(posedge clk) begin
		if (en) begin
			fc_s <= {fc_s[FC-2:0], fault_s2};
		end
	end

	pps_xform u_xform (
		.clk(clk),
		.en(en),
		.cfg(cfg),
		.pos_x(src_x),
		.pos_y(src_y),
		.pos_z(src_z),
		.eye_s2(eye_s2),
		.fault_s2(fault_s2)
	);

	pps_proj u_proj (
		.clk(clk),
		.en(en),
		.cfg(cfg),
		.eye(eye_s2),
		.sc_s8(sc_s8)
	);

	pps_div u_div_x (
		.clk(clk),
		.en(en),
		.num(sc_s8.px),
		.den(sc_s8.dx),
		.neg(sc_s8.negx),
		.res(res_x)
	);

	pps_div u_div_y (
		.clk(clk),
		.en(en),
		.num(sc_s8.py),
		.den(sc_s8.dy),
		.neg(sc_s8.negy),
		.res(res_y)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_fault_q <= fc_s[FC-1];
			out_x_q <= fc_s[FC-1] ? '0 : res_x;
			out_y_q <= fc_s[FC-1] ? '0 : res_y;
		end
	end

	assign screen.valid = out_valid_q;
	assign screen.screen_x = out_x_q;
	assign screen.screen_y = out_y_q;
	assign screen.fault = out_fault_q;

	// a faulted result carries zero coordinates
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_fault_q |-> out_x_q == '0 && out_y_q == '0)
		else $error("faulted result with nonzero coordinates");

	// a stall freezes the last pipeline stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s[NV-1]))
		else $error("pipeline moved during stall");

	// skid keeps its request until the pipeline moves
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !en |=> skid_full_q)
		else $error("skid request lost during stall");

	// skid fills only during a stall
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_full_q && en |=> !skid_full_q)
		else $error("skid filled while pipeline moved");

endmodule
